>>> hw/rtl/shme_pkg.sv
// Shared types, constants and fixed-point helpers for the shearing MHD Euler step block.
`timescale 1ns / 1ps

package shme_pkg;

    localparam int FRAC_BITS = 16;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam int BACK_STAGES   = 7;
    localparam int ENERGY_TERM_W = 63 - FRAC_BITS;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION_RATE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_COS_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VISCOSITY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESISTIVITY     = 3'd4;

    localparam logic [30:0]        DT_RESET    = 31'((1 << FRAC_BITS) >> 2);
    localparam logic signed [31:0] OMEGA_RESET = 32'(-(((2 << FRAC_BITS) + 1) / 3));
    localparam logic signed [17:0] COS_RESET   = 18'(1 << FRAC_BITS);
    localparam logic [30:0]        DAMP_RESET  = 31'(((1 << FRAC_BITS) + 500) / 1000);

    typedef struct packed {
        logic [30:0]        time_step;
        logic signed [31:0] rotation_rate;
        logic signed [17:0] field_cos_angle;
        logic [30:0]        viscosity;
        logic [30:0]        resistivity;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] wavenumber;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] mag_x;
        logic signed [31:0] mag_y;
        logic signed [31:0] mag_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic signed [31:0] new_mag_x;
        logic signed [31:0] new_mag_y;
        logic signed [31:0] new_mag_z;
        logic [31:0]        mode_energy;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } t_comp;

    typedef struct packed {
        logic signed [31:0] qb;
        logic signed [31:0] q2;
        t_comp              comp;
    } t_mid;

    function automatic logic signed [31:0] sat64(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] sat36(input logic signed [35:0] x);
        if (x > 36'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -36'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat64(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] coriolis(input logic signed [31:0] w,
                                                    input logic signed [31:0] x);
        logic signed [63:0] p;
        p = 64'(w) * 64'(x);
        return sat64(p >>> (FRAC_BITS - 1));
    endfunction

    function automatic logic [ENERGY_TERM_W-1:0] square_term(input logic signed [31:0] x);
        logic signed [63:0] p;
        p = 64'(x) * 64'(x);
        return p[ENERGY_TERM_W+FRAC_BITS-1:FRAC_BITS];
    endfunction

endpackage

>>> hw/rtl/shme_front.sv
// Front end: accepts modes and forms the scaled wavenumber and its square.
`timescale 1ns / 1ps

module shme_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  shme_pkg::t_in_item i_item,
    input  shme_pkg::t_cfg    i_cfg,
    output logic              o_mid_valid,
    input  logic              i_mid_ready,
    output shme_pkg::t_mid    o_mid
);
    import shme_pkg::*;

    logic               r_a_vld;
    t_in_item           r_a_item;
    logic               r_b_vld;
    t_mid               r_b_mid;
    logic               a_ready;
    logic               b_ready;
    logic signed [31:0] cos_ext;

    assign b_ready = !r_b_vld || i_mid_ready;
    assign a_ready = !r_a_vld || b_ready;
    assign o_stall = !a_ready;
    assign cos_ext = 32'(i_cfg.field_cos_angle);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_vld <= i_valid;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_item <= i_item;
        end
        if (b_ready && r_a_vld) begin
            r_b_mid.qb      <= fmul(r_a_item.wavenumber, cos_ext);
            r_b_mid.q2      <= fmul(r_a_item.wavenumber, r_a_item.wavenumber);
            r_b_mid.comp.vx <= r_a_item.vel_x;
            r_b_mid.comp.vy <= r_a_item.vel_y;
            r_b_mid.comp.vz <= r_a_item.vel_z;
            r_b_mid.comp.bx <= r_a_item.mag_x;
            r_b_mid.comp.by <= r_a_item.mag_y;
            r_b_mid.comp.bz <= r_a_item.mag_z;
        end
    end

    assign o_mid_valid = r_b_vld;
    assign o_mid       = r_b_mid;

endmodule

>>> hw/rtl/shme_queue.sv
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module shme_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  shme_pkg::t_mid i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output shme_pkg::t_mid o_pop_data
);
    import shme_pkg::*;

    t_mid                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count did not grow on a lone push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !push |=> r_count + 1'b1 == $past(r_count))
        else $error("queue count did not shrink on a lone pop");

endmodule

>>> hw/rtl/shme_back.sv
// Back end: damping factors, derivative terms, Euler update and mode energy.
`timescale 1ns / 1ps

module shme_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_mid_valid,
    output logic               o_mid_ready,
    input  shme_pkg::t_mid     i_mid,
    input  shme_pkg::t_cfg     i_cfg,
    output logic               o_valid,
    input  logic               i_stall,
    output shme_pkg::t_out_item o_result
);
    import shme_pkg::*;

    logic [BACK_STAGES-1:0] r_vld;
    logic [BACK_STAGES:0]   rdy;

    logic signed [31:0] omega;
    logic signed [31:0] nu_ext;
    logic signed [31:0] eta_ext;
    logic signed [31:0] dt_ext;

    t_comp              r_c_comp;
    logic signed [31:0] r_c_qb;
    logic signed [31:0] r_c_kv;
    logic signed [31:0] r_c_km;

    t_comp              r_d_comp;
    logic signed [31:0] r_d_cor_vy;
    logic signed [31:0] r_d_cor_vx;
    logic signed [31:0] r_d_qb_bx;
    logic signed [31:0] r_d_qb_by;
    logic signed [31:0] r_d_qb_bz;
    logic signed [31:0] r_d_qb_vx;
    logic signed [31:0] r_d_qb_vy;
    logic signed [31:0] r_d_qb_vz;
    logic signed [31:0] r_d_kv_vx;
    logic signed [31:0] r_d_kv_vy;
    logic signed [31:0] r_d_kv_vz;
    logic signed [31:0] r_d_km_bx;
    logic signed [31:0] r_d_km_by;
    logic signed [31:0] r_d_km_bz;

    t_comp r_e_comp;
    t_comp r_e_drv;
    t_comp r_f_comp;
    t_comp r_f_upd;
    t_comp r_g_new;
    t_comp r_h_new;

    logic [ENERGY_TERM_W-1:0] r_h_sq_vx;
    logic [ENERGY_TERM_W-1:0] r_h_sq_vy;
    logic [ENERGY_TERM_W-1:0] r_h_sq_bx;
    logic [ENERGY_TERM_W-1:0] r_h_sq_by;
    logic [ENERGY_TERM_W+1:0] energy_sum;

    t_out_item r_out;

    assign omega   = i_cfg.rotation_rate;
    assign nu_ext  = $signed({1'b0, i_cfg.viscosity});
    assign eta_ext = $signed({1'b0, i_cfg.resistivity});
    assign dt_ext  = $signed({1'b0, i_cfg.time_step});

    always_comb begin
        rdy[BACK_STAGES] = !i_stall;
        for (int k = BACK_STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_mid_ready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_mid_valid;
            end
            for (int k = 1; k < BACK_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_mid_valid) begin
            r_c_comp <= i_mid.comp;
            r_c_qb   <= i_mid.qb;
            r_c_kv   <= fmul(nu_ext, i_mid.q2);
            r_c_km   <= fmul(eta_ext, i_mid.q2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1] && r_vld[0]) begin
            r_d_comp   <= r_c_comp;
            r_d_cor_vy <= coriolis(omega, r_c_comp.vy);
            r_d_cor_vx <= coriolis(omega, r_c_comp.vx);
            r_d_qb_bx  <= fmul(r_c_qb, r_c_comp.bx);
            r_d_qb_by  <= fmul(r_c_qb, r_c_comp.by);
            r_d_qb_bz  <= fmul(r_c_qb, r_c_comp.bz);
            r_d_qb_vx  <= fmul(r_c_qb, r_c_comp.vx);
            r_d_qb_vy  <= fmul(r_c_qb, r_c_comp.vy);
            r_d_qb_vz  <= fmul(r_c_qb, r_c_comp.vz);
            r_d_kv_vx  <= fmul(r_c_kv, r_c_comp.vx);
            r_d_kv_vy  <= fmul(r_c_kv, r_c_comp.vy);
            r_d_kv_vz  <= fmul(r_c_kv, r_c_comp.vz);
            r_d_km_bx  <= fmul(r_c_km, r_c_comp.bx);
            r_d_km_by  <= fmul(r_c_km, r_c_comp.by);
            r_d_km_bz  <= fmul(r_c_km, r_c_comp.bz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2] && r_vld[1]) begin
            r_e_comp   <= r_d_comp;
            r_e_drv.vx <= sat36(36'(r_d_cor_vy) + 36'(r_d_qb_bx) - 36'(r_d_kv_vx));
            r_e_drv.vy <= sat36(-36'(r_d_comp.vx) - 36'(r_d_cor_vx) + 36'(r_d_qb_by)
                                - 36'(r_d_kv_vy));
            r_e_drv.vz <= sat36(36'(r_d_qb_bz) - 36'(r_d_kv_vz));
            r_e_drv.bx <= sat36(-36'(r_d_qb_vx) - 36'(r_d_km_bx));
            r_e_drv.by <= sat36(36'(r_d_comp.bx) - 36'(r_d_qb_vy) - 36'(r_d_km_by));
            r_e_drv.bz <= sat36(-36'(r_d_qb_vz) - 36'(r_d_km_bz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3] && r_vld[2]) begin
            r_f_comp   <= r_e_comp;
            r_f_upd.vx <= fmul(r_e_drv.vx, dt_ext);
            r_f_upd.vy <= fmul(r_e_drv.vy, dt_ext);
            r_f_upd.vz <= fmul(r_e_drv.vz, dt_ext);
            r_f_upd.bx <= fmul(r_e_drv.bx, dt_ext);
            r_f_upd.by <= fmul(r_e_drv.by, dt_ext);
            r_f_upd.bz <= fmul(r_e_drv.bz, dt_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4] && r_vld[3]) begin
            r_g_new.vx <= sat36(36'(r_f_comp.vx) + 36'(r_f_upd.vx));
            r_g_new.vy <= sat36(36'(r_f_comp.vy) + 36'(r_f_upd.vy));
            r_g_new.vz <= sat36(36'(r_f_comp.vz) + 36'(r_f_upd.vz));
            r_g_new.bx <= sat36(36'(r_f_comp.bx) + 36'(r_f_upd.bx));
            r_g_new.by <= sat36(36'(r_f_comp.by) + 36'(r_f_upd.by));
            r_g_new.bz <= sat36(36'(r_f_comp.bz) + 36'(r_f_upd.bz));
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5] && r_vld[4]) begin
            r_h_new   <= r_g_new;
            r_h_sq_vx <= square_term(r_g_new.vx);
            r_h_sq_vy <= square_term(r_g_new.vy);
            r_h_sq_bx <= square_term(r_g_new.bx);
            r_h_sq_by <= square_term(r_g_new.by);
        end
    end

    assign energy_sum = (ENERGY_TERM_W + 2)'(r_h_sq_vx) + (ENERGY_TERM_W + 2)'(r_h_sq_vy)
                      + (ENERGY_TERM_W + 2)'(r_h_sq_bx) + (ENERGY_TERM_W + 2)'(r_h_sq_by);

    always_ff @(posedge i_clk) begin
        if (rdy[6] && r_vld[5]) begin
            r_out.new_vel_x <= r_h_new.vx;
            r_out.new_vel_y <= r_h_new.vy;
            r_out.new_vel_z <= r_h_new.vz;
            r_out.new_mag_x <= r_h_new.bx;
            r_out.new_mag_y <= r_h_new.by;
            r_out.new_mag_z <= r_h_new.bz;
            if (|energy_sum[ENERGY_TERM_W+1:32]) begin
                r_out.mode_energy <= 32'hFFFF_FFFF;
            end else begin
                r_out.mode_energy <= energy_sum[31:0];
            end
        end
    end

    assign o_valid  = r_vld[BACK_STAGES-1];
    assign o_result = r_out;

endmodule

>>> hw/rtl/shearing_mhd_euler_step.sv
// Top level of the shearing-box MHD Euler step: configuration registers and block wiring.
`timescale 1ns / 1ps

// The block takes one Fourier mode per clock when not stalled and returns its updated
// components and energy, with no reset sweep; throughput is one mode per cycle when
// unstalled, set by the fully pipelined multiplier lanes of the front and back ends,
// and a four-entry queue between them absorbs stalls from the result side.
module shearing_mhd_euler_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  shme_pkg::t_in_item            i_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output shme_pkg::t_out_item           o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [shme_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);
    import shme_pkg::*;

    t_cfg r_cfg;
    logic mid_valid;
    logic mid_ready;
    t_mid mid_data;
    logic q_valid;
    logic q_ready;
    t_mid q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step       <= DT_RESET;
            r_cfg.rotation_rate   <= OMEGA_RESET;
            r_cfg.field_cos_angle <= COS_RESET;
            r_cfg.viscosity       <= DAMP_RESET;
            r_cfg.resistivity     <= DAMP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TIME_STEP:       r_cfg.time_step       <= i_cfg_data[30:0];
                REG_ROTATION_RATE:   r_cfg.rotation_rate   <= $signed(i_cfg_data);
                REG_FIELD_COS_ANGLE: r_cfg.field_cos_angle <= $signed(i_cfg_data[17:0]);
                REG_VISCOSITY:       r_cfg.viscosity       <= i_cfg_data[30:0];
                REG_RESISTIVITY:     r_cfg.resistivity     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    shme_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .o_mid_valid (mid_valid),
        .i_mid_ready (mid_ready),
        .o_mid       (mid_data)
    );

    shme_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (mid_valid),
        .o_push_ready (mid_ready),
        .i_push_data  (mid_data),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    shme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (q_valid),
        .o_mid_ready (q_ready),
        .i_mid       (q_data),
        .i_cfg       (r_cfg),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

endmodule
